### sv/word_punctuation_tokenizer_assert.svh
// Assertion macros for the tokenizer datapath module.
// Self-contained; included by the modules that carry assertions.
`ifndef WORD_PUNCTUATION_TOKENIZER_ASSERT_SVH
`define WORD_PUNCTUATION_TOKENIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Condition a implies condition c on the same edge.
`define WPT_ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tokenizer check failed");
// Condition a implies condition c on the following edge.
`define WPT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tokenizer check failed");
`else
`define WPT_ASSERT_SAME(label, clk, rst_n, a, c)
`define WPT_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### sv/wpt_pkg.sv
// Package for the word and punctuation tokenizer: widths, codes and the
// command and status structs between controller and datapath. No dependencies.
package wpt_pkg;

    localparam int CHAR_W            = 16;
    localparam int NUM_CODES         = 6;
    localparam int PCOUNT_W          = 3;
    localparam int CFG_IDX_W         = 3;
    localparam int MAX_TRAIL_DEFAULT = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PUNCT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BASE   = 3'd1;

    // Reset values of the configuration registers.
    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 3'd6;
    localparam logic [CHAR_W-1:0] PCODE_RESET [NUM_CODES] =
        '{16'd46, 16'd44, 16'd33, 16'd63, 16'd59, 16'd58};

    // Whitespace codes.
    localparam logic [CHAR_W-1:0] WS_LOW   = 16'd9;
    localparam logic [CHAR_W-1:0] WS_HIGH  = 16'd13;
    localparam logic [CHAR_W-1:0] WS_SPACE = 16'd32;

    // Action taken for an accepted character that produces results.
    localparam logic [1:0] ACT_WORD_END = 2'd0;
    localparam logic [1:0] ACT_LETTER   = 2'd1;
    localparam logic [1:0] ACT_PUNCT    = 2'd2;
    localparam logic [1:0] ACT_OVERFLOW = 2'd3;

    typedef struct packed {
        logic in_ready;
        logic load_head;
        logic load_drain;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic emit;
        logic has_pending;
        logic drain_last;
        logic out_free;
    } t_status;

endpackage

### sv/wpt_in_if.sv
// Input channel of the tokenizer: one source character per transaction.
// Depends on wpt_pkg.
interface wpt_in_if
    import wpt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

### sv/wpt_out_if.sv
// Output channel of the tokenizer: one token character per transaction.
// Depends on wpt_pkg.
interface wpt_out_if
    import wpt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              kind;
    logic              token_end;
    logic              last;
    logic              overflow;

    modport source (output valid, output out_char, output kind, output token_end,
                    output last, output overflow, input ready);
    modport sink   (input valid, input out_char, input kind, input token_end,
                    input last, input overflow, output ready);
endinterface

### sv/wpt_ctrl.sv
// Controller of the tokenizer: sequences accept, first result and queue drain.
// Depends on wpt_pkg.
module wpt_ctrl
    import wpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HEAD  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Commands follow directly from the state and the output slot.
    always_comb begin
        o_cmd.in_ready   = (r_state == S_IDLE);
        o_cmd.load_head  = (r_state == S_HEAD) && i_sts.out_free;
        o_cmd.load_drain = (r_state == S_DRAIN) && i_sts.out_free;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid && i_sts.emit) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.has_pending ? S_DRAIN : S_IDLE;
                end
            end
            S_DRAIN: begin
                if (i_sts.out_free && i_sts.drain_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/wpt_dp.sv
// Datapath of the tokenizer: configuration, classification, word state,
// pending queue and output register. Depends on wpt_pkg and the channel interfaces.
`include "word_punctuation_tokenizer_assert.svh"
module wpt_dp
    import wpt_pkg::*;
#(
    parameter int MAX_TRAIL = MAX_TRAIL_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_sts,
    wpt_in_if.sink               i_in,
    wpt_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CHAR_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_TRAIL + 1);
    localparam int IW = (MAX_TRAIL > 1) ? $clog2(MAX_TRAIL) : 1;

    // Configuration registers.
    logic [PCOUNT_W-1:0] r_pcount;
    logic [CHAR_W-1:0]   r_pcode [NUM_CODES];

    // Word state and pending punctuation.
    logic                r_in_word;
    logic [CHAR_W-1:0]   r_held;
    logic [CHAR_W-1:0]   r_pend [MAX_TRAIL];
    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_idx;

    // Accepted character and its action.
    logic [CHAR_W-1:0]   r_char;
    logic [1:0]          r_act;

    // Output register.
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_kind;
    logic                r_out_end;
    logic                r_out_last;
    logic                r_out_ovf;

    logic                accept;
    logic                is_space;
    logic                is_punct;
    logic [PCOUNT_W-1:0] n_codes;
    logic                queue_full;
    logic [1:0]          act_d;
    logic                emit_d;
    logic                push_d;
    logic                open_d;
    logic                out_free;
    logic                drain_last;
    logic                pend_zero;

    assign accept     = i_in.valid && i_cmd.in_ready;
    assign i_in.ready = i_cmd.in_ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign queue_full = (r_count >= CW'(MAX_TRAIL));
    assign pend_zero  = (r_count == '0);
    assign drain_last = ((CW'(r_idx) + CW'(1)) == r_count);

    // Character classes; whitespace wins over a matching punctuation code.
    always_comb begin
        is_space = ((i_in.char_code >= WS_LOW) && (i_in.char_code <= WS_HIGH))
                   || (i_in.char_code == WS_SPACE);
        n_codes  = (r_pcount > PCOUNT_W'(NUM_CODES)) ? PCOUNT_W'(NUM_CODES) : r_pcount;
        is_punct = 1'b0;
        for (int i = 0; i < NUM_CODES; i++) begin
            if ((PCOUNT_W'(i) < n_codes) && (r_pcode[i] == i_in.char_code)) begin
                is_punct = 1'b1;
            end
        end
    end

    // Decide what the offered character does.
    always_comb begin
        act_d  = ACT_PUNCT;
        emit_d = 1'b0;
        push_d = 1'b0;
        open_d = 1'b0;
        if (r_in_word) begin
            if (i_in.end_of_text || is_space) begin
                act_d  = ACT_WORD_END;
                emit_d = 1'b1;
            end else if (is_punct) begin
                if (queue_full) begin
                    act_d  = ACT_OVERFLOW;
                    emit_d = 1'b1;
                end else begin
                    push_d = 1'b1;
                end
            end else begin
                act_d  = ACT_LETTER;
                emit_d = 1'b1;
            end
        end else if (!i_in.end_of_text && !is_space) begin
            if (is_punct) begin
                act_d  = ACT_PUNCT;
                emit_d = 1'b1;
            end else begin
                open_d = 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.in_valid    = i_in.valid;
        o_sts.emit        = emit_d;
        o_sts.has_pending = !pend_zero
                            && ((r_act == ACT_WORD_END) || (r_act == ACT_LETTER));
        o_sts.drain_last  = drain_last;
        o_sts.out_free    = out_free;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= PCOUNT_RESET;
            for (int k = 0; k < NUM_CODES; k++) begin
                r_pcode[k] <= PCODE_RESET[k];
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_PUNCT_COUNT) begin
                r_pcount <= i_cfg_data[PCOUNT_W-1:0];
            end
            for (int k = 0; k < NUM_CODES; k++) begin
                if (i_cfg_idx == (CFG_CODE_BASE + CFG_IDX_W'(k))) begin
                    r_pcode[k] <= i_cfg_data;
                end
            end
        end
    end

    // Capture of the accepted character and its action.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_in.char_code;
            r_act  <= act_d;
        end
    end

    // Pending queue storage.
    always_ff @(posedge i_clk) begin
        if (accept && push_d) begin
            r_pend[r_count[IW-1:0]] <= i_in.char_code;
        end
    end

    // Word state, fill count and drain index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word <= 1'b0;
            r_held    <= '0;
            r_count   <= '0;
            r_idx     <= '0;
        end else begin
            if (accept && open_d) begin
                r_held    <= i_in.char_code;
                r_in_word <= 1'b1;
                r_count   <= '0;
            end
            if (accept && push_d) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.load_head) begin
                if (r_act == ACT_LETTER) begin
                    r_held <= r_char;
                end
                if ((r_act == ACT_WORD_END) && pend_zero) begin
                    r_in_word <= 1'b0;
                end
            end
            if (i_cmd.load_drain) begin
                if (drain_last) begin
                    r_idx   <= '0;
                    r_count <= '0;
                    if (r_act == ACT_WORD_END) begin
                        r_in_word <= 1'b0;
                    end
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_head || i_cmd.load_drain) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload: first result, then queued characters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_head) begin
            case (r_act)
                ACT_WORD_END: begin
                    r_out_char <= r_held;
                    r_out_kind <= 1'b0;
                    r_out_end  <= 1'b1;
                    r_out_last <= pend_zero;
                    r_out_ovf  <= 1'b0;
                end
                ACT_LETTER: begin
                    r_out_char <= r_held;
                    r_out_kind <= 1'b0;
                    r_out_end  <= 1'b0;
                    r_out_last <= pend_zero;
                    r_out_ovf  <= 1'b0;
                end
                ACT_OVERFLOW: begin
                    r_out_char <= r_char;
                    r_out_kind <= 1'b1;
                    r_out_end  <= 1'b0;
                    r_out_last <= 1'b1;
                    r_out_ovf  <= 1'b1;
                end
                default: begin
                    r_out_char <= r_char;
                    r_out_kind <= 1'b1;
                    r_out_end  <= 1'b1;
                    r_out_last <= 1'b1;
                    r_out_ovf  <= 1'b0;
                end
            endcase
        end else if (i_cmd.load_drain) begin
            r_out_char <= r_pend[r_idx];
            r_out_kind <= (r_act == ACT_WORD_END);
            r_out_end  <= (r_act == ACT_WORD_END);
            r_out_last <= drain_last;
            r_out_ovf  <= 1'b0;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_char  = r_out_char;
    assign o_out.kind      = r_out_kind;
    assign o_out.token_end = r_out_end;
    assign o_out.last      = r_out_last;
    assign o_out.overflow  = r_out_ovf;

    // The fill count never passes the queue depth.
    `WPT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_TRAIL))
    // Outside a word the pending queue is empty.
    `WPT_ASSERT_SAME(a_idle_empty, i_clk, i_rst_n, !r_in_word, r_count == '0)
    // A drain step only runs on a non-empty queue.
    `WPT_ASSERT_SAME(a_drain_nonempty, i_clk, i_rst_n, i_cmd.load_drain, !pend_zero)
    // A drop notice is a punctuation record that closes nothing and ends the item.
    `WPT_ASSERT_SAME(a_ovf_shape, i_clk, i_rst_n, r_out_valid && r_out_ovf,
                     r_out_kind && !r_out_end && r_out_last)
    // The last queued character clears the queue.
    `WPT_ASSERT_NEXT(a_drain_clears, i_clk, i_rst_n,
                     i_cmd.load_drain && drain_last, r_count == '0)

endmodule

### sv/word_punctuation_tokenizer.sv
// Channel     | Dir | Payload                                      | Handshake
// i_in        | in  | char_code[15:0], end_of_text                 | valid/ready
// o_out       | out | out_char[15:0], kind, token_end, last, overflow | valid/ready
// i_cfg_*     | in  | i_cfg_idx[2:0], i_cfg_data[15:0]             | write enable
// A character that yields no result is only accepted; the sequencer stays idle. One that
// yields results is accepted, then its first result and any pending characters load into the
// single output register, one result per cycle while the output is not stalled.
// Reset is synchronous and active low; it restores the punctuation set.
// A stalled output holds the sequencer; input is taken only between items.
// Top level of the word and punctuation tokenizer. Depends on wpt_pkg,
// wpt_in_if, wpt_out_if, wpt_ctrl and wpt_dp.
module word_punctuation_tokenizer
    import wpt_pkg::*;
#(
    parameter int MAX_TRAIL = MAX_TRAIL_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    wpt_in_if.sink               i_in,
    wpt_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CHAR_W-1:0]    i_cfg_data
);

    t_cmd    cmd;
    t_status sts;

    // Sequencer.
    wpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath with configuration, queue and output register.
    wpt_dp #(
        .MAX_TRAIL (MAX_TRAIL)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule
